// ===== rtl/core/vau_pkg.sv =====
// Shared types and constants for the vector angle unit.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package vau_pkg;

	// Angle accumulator, Q.29 radians, with headroom for the pi fold
	localparam int ZW = 33;
	// Rounded angle before saturation, Q3.13 with one spare bit
	localparam int AW = ZW - 16;
	localparam int ANGLE_W = 16;
	localparam int ROUND_SHIFT = 16;

	localparam logic signed [ZW-1:0] PI_Q29 = 33'sd1686629713;
	localparam logic signed [AW-1:0] PI_Q13 = 17'sd25736;
	localparam logic signed [ZW-1:0] ROUND_HALF = 33'sd32768;

	localparam logic [28:0] ATAN_Q29 [32] = '{
		29'd421657428, 29'd248918915, 29'd131521918, 29'd66762579,
		29'd33510843,  29'd16771758,  29'd8387925,   29'd4194219,
		29'd2097141,   29'd1048575,   29'd524288,    29'd262144,
		29'd131072,    29'd65536,     29'd32768,     29'd16384,
		29'd8192,      29'd4096,      29'd2048,      29'd1024,
		29'd512,       29'd256,       29'd128,       29'd64,
		29'd32,        29'd16,        29'd8,         29'd4,
		29'd2,         29'd1,         29'd0,         29'd0
	};

	typedef struct packed {
		logic vld;
		logic sgn;
		logic zero;
	} ctl_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic                      zero;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/vau_front.sv =====
// Front end: products, dot and cross sums, fold into the right half plane.
// Three pipeline stages; uses vau_pkg.
`default_nettype none

module vau_front #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int XW = 35
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              req_valid,
	input  wire logic                              cmd,
	input  wire logic signed [COMPONENT_WIDTH-1:0] from_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] from_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0] to_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] to_y,
	output vau_pkg::ctl_t                          ctl_s3,
	output logic signed [XW-1:0]                   x_s3,
	output logic signed [XW-1:0]                   y_s3,
	output logic signed [vau_pkg::ZW-1:0]          z_s3
);

	localparam int PROD_W = 2 * COMPONENT_WIDTH;
	localparam int SH = (PROD_W > 32) ? PROD_W - 32 : 0;
	localparam int PW = PROD_W - SH;
	localparam int SW = PW + 1;

	vau_pkg::ctl_t ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0] p_xx_s1, p_yy_s1, p_xy_s1, p_yx_s1;
	logic signed [SW-1:0] dot_s2, cross_s2;

	logic signed [PROD_W-1:0] p_xx, p_yy, p_xy, p_yx;
	logic signed [PW-1:0] sc_xx, sc_yy, sc_xy, sc_yx;
	logic signed [SW-1:0] dot_c, cross_c;
	logic signed [XW-1:0] x_c, y_c;
	logic signed [vau_pkg::ZW-1:0] z_c;
	logic zero_c;

	assign p_xx = PROD_W'(from_x) * PROD_W'(to_x);
	assign p_yy = PROD_W'(from_y) * PROD_W'(to_y);
	assign p_xy = PROD_W'(from_x) * PROD_W'(to_y);
	assign p_yx = PROD_W'(from_y) * PROD_W'(to_x);
	assign zero_c = ((from_x == '0) && (from_y == '0)) || ((to_x == '0) && (to_y == '0));

	assign sc_xx = $signed(p_xx_s1[PROD_W-1:SH]);
	assign sc_yy = $signed(p_yy_s1[PROD_W-1:SH]);
	assign sc_xy = $signed(p_xy_s1[PROD_W-1:SH]);
	assign sc_yx = $signed(p_yx_s1[PROD_W-1:SH]);
	assign dot_c = SW'(sc_xx) + SW'(sc_yy);
	assign cross_c = SW'(sc_xy) - SW'(sc_yx);

	always_comb begin
		if (dot_s2[SW-1]) begin
			x_c = -XW'(dot_s2);
			y_c = -XW'(cross_s2);
			z_c = cross_s2[SW-1] ? -vau_pkg::PI_Q29 : vau_pkg::PI_Q29;
		end else begin
			x_c = XW'(dot_s2);
			y_c = XW'(cross_s2);
			z_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: req_valid, sgn: cmd, zero: zero_c};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1  <= p_xx;
			p_yy_s1  <= p_yy;
			p_xy_s1  <= p_xy;
			p_yx_s1  <= p_yx;
			dot_s2   <= dot_c;
			cross_s2 <= cross_c;
			x_s3     <= x_c;
			y_s3     <= y_c;
			z_s3     <= z_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vau_cordic_stage.sv =====
// One vectoring rotation of the arctangent pipeline, registered.
// Uses vau_pkg for the arctangent table and control type.
`default_nettype none

module vau_cordic_stage #(
	parameter int XW = 35,
	parameter int IDX = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire vau_pkg::ctl_t                     ctl_in,
	input  wire logic signed [XW-1:0]              x_in,
	input  wire logic signed [XW-1:0]              y_in,
	input  wire logic signed [vau_pkg::ZW-1:0]     z_in,
	output vau_pkg::ctl_t                          ctl_q,
	output logic signed [XW-1:0]                   x_q,
	output logic signed [XW-1:0]                   y_q,
	output logic signed [vau_pkg::ZW-1:0]          z_q
);

	localparam logic signed [vau_pkg::ZW-1:0] STEP_ANGLE =
		vau_pkg::ZW'(vau_pkg::ATAN_Q29[IDX]);

	logic signed [XW-1:0] dx, dy, x_c, y_c;
	logic signed [vau_pkg::ZW-1:0] z_c;
	logic y_pos, y_neg;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;
	assign y_neg = y_in[XW-1];
	assign y_pos = !y_in[XW-1] && (y_in != '0);

	always_comb begin
		x_c = x_in;
		y_c = y_in;
		z_c = z_in;
		if (y_pos) begin
			x_c = x_in + dx;
			y_c = y_in - dy;
			z_c = z_in + STEP_ANGLE;
		end else if (y_neg) begin
			x_c = x_in - dx;
			y_c = y_in + dy;
			z_c = z_in - STEP_ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_c;
			y_q <= y_c;
			z_q <= z_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vau_back.sv =====
// Back end: round to Q3.13, saturate to +-pi, fold to magnitude in unsigned mode, zero override.
// Two pipeline stages; uses vau_pkg.
`default_nettype none

module vau_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire vau_pkg::ctl_t                 ctl_in,
	input  wire logic signed [vau_pkg::ZW-1:0] z_in,
	output vau_pkg::ctl_t                      ctl_s2,
	output vau_pkg::res_t                      res_s2
);

	localparam int AW = vau_pkg::AW;
	localparam int ZW = vau_pkg::ZW;
	localparam int ANGLE_W = vau_pkg::ANGLE_W;

	vau_pkg::ctl_t ctl_s1;
	logic signed [AW-1:0] a_s1;

	logic signed [ZW-1:0] rnd_c;
	logic signed [AW-1:0] sat_c, fold_c;
	vau_pkg::res_t res_c;

	assign rnd_c = z_in + vau_pkg::ROUND_HALF;

	always_comb begin
		if (a_s1 > vau_pkg::PI_Q13) begin
			sat_c = vau_pkg::PI_Q13;
		end else if (a_s1 < -vau_pkg::PI_Q13) begin
			sat_c = -vau_pkg::PI_Q13;
		end else begin
			sat_c = a_s1;
		end
		fold_c = (!ctl_s1.sgn && sat_c[AW-1]) ? -sat_c : sat_c;
		res_c.zero = ctl_s1.zero;
		res_c.angle = ctl_s1.zero ? '0 : $signed(fold_c[ANGLE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= $signed(rnd_c[ZW-1:vau_pkg::ROUND_SHIFT]);
			res_s2 <= res_c;
		end
	end

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld |-> (res_s2.angle <= 16'sd25736) && (res_s2.angle >= -16'sd25736))
		else $error("angle outside +-pi");

	a_unsigned_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld && !ctl_s2.sgn |-> !res_s2.angle[ANGLE_W-1])
		else $error("negative angle in unsigned mode");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld && res_s2.zero |-> (res_s2.angle == '0))
		else $error("zero vector with non-zero angle");

endmodule

`default_nettype wire

// ===== rtl/core/vau_out_buffer.sv =====
// Output register with one-entry skid; produces the pipeline advance enable.
// Uses vau_pkg result type.
`default_nettype none

module vau_out_buffer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              tail_vld,
	input  wire vau_pkg::res_t                     tail_res,
	output logic                                   en,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic signed [vau_pkg::ANGLE_W-1:0]     angle,
	output logic                                   zero_vector
);

	logic out_v_q, skid_v_q;
	vau_pkg::res_t out_d_q, skid_d_q;
	logic take, push;

	assign en = !skid_v_q;
	assign take = out_v_q && !rsp_stall;
	assign push = en && tail_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || take) begin
				out_d_q <= tail_res;
			end else begin
				skid_d_q <= tail_res;
			end
		end else if (take && skid_v_q) begin
			out_d_q <= skid_d_q;
		end
	end

	assign rsp_valid = out_v_q;
	assign angle = out_d_q.angle;
	assign zero_vector = out_d_q.zero;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a transaction while output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_v_q && rsp_stall |=> skid_v_q)
		else $error("stalled push not captured in skid");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take && skid_v_q |=> out_v_q && !skid_v_q)
		else $error("skid not drained into output");

endmodule

`default_nettype wire

// ===== rtl/core/vector_angle_unit.sv =====
// channel | signals                                   | handshake
// req     | cmd, from_x, from_y, to_x, to_y           | req_valid / req_stall
// rsp     | angle, zero_vector                        | rsp_valid / rsp_stall
//
// One transaction per cycle while req_stall is low; a result passes through three front
// stages, one stage per rotation, two back stages and the output register.
// req_stall rises only when the output skid entry is occupied.
// arst_n clears all valid bits; no clearing pass.
`default_nettype none

module vector_angle_unit #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int ROTATION_STAGES = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic                              cmd,
	input  wire logic signed [COMPONENT_WIDTH-1:0] from_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] from_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0] to_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] to_y,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic signed [vau_pkg::ANGLE_W-1:0]     angle,
	output logic                                   zero_vector
);

	localparam int PROD_W = 2 * COMPONENT_WIDTH;
	localparam int SH = (PROD_W > 32) ? PROD_W - 32 : 0;
	localparam int SW = PROD_W - SH + 1;
	localparam int XW = SW + 2;

	logic en;
	vau_pkg::ctl_t ctl_pipe [ROTATION_STAGES+1];
	logic signed [XW-1:0] x_pipe [ROTATION_STAGES+1];
	logic signed [XW-1:0] y_pipe [ROTATION_STAGES+1];
	logic signed [vau_pkg::ZW-1:0] z_pipe [ROTATION_STAGES+1];
	vau_pkg::ctl_t tail_ctl;
	vau_pkg::res_t tail_res;

	assign req_stall = !en;

	vau_front #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH),
		.XW(XW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.req_valid(req_valid),
		.cmd(cmd),
		.from_x(from_x),
		.from_y(from_y),
		.to_x(to_x),
		.to_y(to_y),
		.ctl_s3(ctl_pipe[0]),
		.x_s3(x_pipe[0]),
		.y_s3(y_pipe[0]),
		.z_s3(z_pipe[0])
	);

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
		vau_cordic_stage #(
			.XW(XW),
			.IDX(i)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.ctl_in(ctl_pipe[i]),
			.x_in(x_pipe[i]),
			.y_in(y_pipe[i]),
			.z_in(z_pipe[i]),
			.ctl_q(ctl_pipe[i+1]),
			.x_q(x_pipe[i+1]),
			.y_q(y_pipe[i+1]),
			.z_q(z_pipe[i+1])
		);
	end

	vau_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ctl_in(ctl_pipe[ROTATION_STAGES]),
		.z_in(z_pipe[ROTATION_STAGES]),
		.ctl_s2(tail_ctl),
		.res_s2(tail_res)
	);

	vau_out_buffer u_out (
		.clk(clk),
		.arst_n(arst_n),
		.tail_vld(tail_ctl.vld),
		.tail_res(tail_res),
		.en(en),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.angle(angle),
		.zero_vector(zero_vector)
	);

endmodule

`default_nettype wire
